@@ design/binary_lifting_lca_top_defines.svh @@
// Assertion macros for the binary lifting ancestor engine.
`ifndef BINARY_LIFTING_LCA_TOP_DEFINES_SVH
`define BINARY_LIFTING_LCA_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLCA_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLCA_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ design/blca_pkg.sv @@
// Shared constants, codes and control types of the ancestor engine.
`default_nettype none
package blca_pkg;

   localparam int MAX_NODES    = 1024;
   localparam int NODE_W       = 10;
   localparam int DEPTH_W      = 11;
   localparam int LEVELS_DEF   = 10;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_WR,
      ST_Q_SWAP,
      ST_Q_L1,
      ST_Q_L2,
      ST_Q_L3,
      ST_Q_EQ,
      ST_Q_M1,
      ST_Q_M2,
      ST_Q_F1,
      ST_Q_F2,
      ST_Q_FIN
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic q_start;
      logic q_swap;
      logic lift_rd;
      logic lift_depth_rd;
      logic lift_upd;
      logic meet_rd;
      logic meet_upd;
      logic fin_rd;
      logic res_from_a;
      logic res_from_rd;
      logic push;
      logic build_rd1;
      logic build_rd2;
      logic build_wr;
      logic lvl_zero;
      logic lvl_top;
      logic lvl_inc;
      logic lvl_dec;
      logic node_zero;
      logic node_inc;
   } cmd_type;

   typedef struct packed {
      logic build_empty;
      logic node_last;
      logic lvl_build_last;
      logic lvl_is_zero;
      logic pair_equal;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ design/blca_dpath.sv @@
// Datapath: jump table, depth store, query registers and result register.
`default_nettype none
module blca_dpath
   import blca_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic [NODE_W-1:0]  node_id,
   input  wire logic [NODE_W-1:0]  parent_id,
   input  wire logic [DEPTH_W-1:0] node_depth,
   input  wire logic [NODE_W-1:0]  first_node,
   input  wire logic [NODE_W-1:0]  second_node,
   input  wire logic               csr_wen,
   input  wire logic [DEPTH_W-1:0] csr_wdata,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [NODE_W-1:0]       ancestor
);

   localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JT_DEPTH = LEVELS * MAX_NODES;
   localparam int JT_AW    = $clog2(JT_DEPTH);
   localparam int LVL_BLD  = (LEVELS > 1) ? LEVELS - 2 : 0;
   localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(LEVELS - 1);
   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LVL_BLD);

   logic [NODE_W-1:0]  jt_mem_ff  [JT_DEPTH];
   logic [DEPTH_W-1:0] dep_mem_ff [MAX_NODES];

   logic [NODE_W-1:0]  jt_a_rd_ff, jt_b_rd_ff;
   logic [DEPTH_W-1:0] dep_a_rd_ff, dep_b_rd_ff;

   logic [NODE_W-1:0]  a_ff, a_in, b_ff, b_in, h_ff, h_in, res_ff, res_in;
   logic [DEPTH_W-1:0] db_ff, db_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [DEPTH_W-1:0] count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   logic [NODE_W-1:0]  out_data_ff;

   logic [DEPTH_W-1:0] build_cnt, build_cnt_m1;
   logic               jt_we, jt_a_re, jt_b_re, dep_a_re, dep_b_re;
   logic [JT_AW-1:0]   jt_waddr, jt_a_addr, jt_b_addr;
   logic [NODE_W-1:0]  jt_wdata, dep_a_addr;

   function automatic logic [JT_AW-1:0] jt_addr(input logic [LVL_W-1:0] lvl,
                                                input logic [NODE_W-1:0] node);
      logic [LVL_W+NODE_W-1:0] cat;
      cat = {lvl, node};
      return cat[JT_AW-1:0];
   endfunction

   // Memory port selection.
   always_comb begin
      jt_we      = cmd.load_wr | cmd.build_wr;
      jt_waddr   = cmd.load_wr ? jt_addr('0, node_id) : jt_addr(lvl_ff + 1'b1, node_ff);
      jt_wdata   = cmd.load_wr ? parent_id : jt_a_rd_ff;
      jt_a_re    = cmd.build_rd1 | cmd.build_rd2 | cmd.lift_rd | cmd.meet_rd | cmd.fin_rd;
      jt_a_addr  = jt_addr(lvl_ff, a_ff);
      if (cmd.build_rd1) begin
         jt_a_addr = jt_addr(lvl_ff, node_ff);
      end else if (cmd.build_rd2) begin
         jt_a_addr = jt_addr(lvl_ff, jt_a_rd_ff);
      end else if (cmd.fin_rd) begin
         jt_a_addr = jt_addr('0, a_ff);
      end
      jt_b_re    = cmd.meet_rd;
      jt_b_addr  = jt_addr(lvl_ff, b_ff);
      dep_a_re   = cmd.q_start | cmd.lift_depth_rd;
      dep_a_addr = cmd.q_start ? first_node : jt_a_rd_ff;
      dep_b_re   = cmd.q_start;
   end

   always_ff @(posedge clock) begin
      if (jt_we) begin
         jt_mem_ff[jt_waddr] <= jt_wdata;
      end
      if (jt_a_re) begin
         jt_a_rd_ff <= jt_mem_ff[jt_a_addr];
      end
      if (jt_b_re) begin
         jt_b_rd_ff <= jt_mem_ff[jt_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         dep_mem_ff[node_id] <= node_depth;
      end
      if (dep_a_re) begin
         dep_a_rd_ff <= dep_mem_ff[dep_a_addr];
      end
      if (dep_b_re) begin
         dep_b_rd_ff <= dep_mem_ff[second_node];
      end
   end

   // Query and build registers.
   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      db_in  = db_ff;
      h_in   = h_ff;
      res_in = res_ff;
      if (cmd.q_start) begin
         a_in = first_node;
         b_in = second_node;
      end
      if (cmd.q_swap) begin
         // keep the deeper node in a
         if (dep_a_rd_ff < dep_b_rd_ff) begin
            a_in  = b_ff;
            b_in  = a_ff;
            db_in = dep_a_rd_ff;
         end else begin
            db_in = dep_b_rd_ff;
         end
      end
      if (cmd.lift_depth_rd) begin
         h_in = jt_a_rd_ff;
      end
      if (cmd.lift_upd && (dep_a_rd_ff >= db_ff)) begin
         a_in = h_ff;
      end
      if (cmd.meet_upd && (jt_a_rd_ff != jt_b_rd_ff)) begin
         a_in = jt_a_rd_ff;
         b_in = jt_b_rd_ff;
      end
      if (cmd.res_from_a) begin
         res_in = a_ff;
      end else if (cmd.res_from_rd) begin
         res_in = jt_a_rd_ff;
      end
   end

   always_comb begin
      lvl_in = lvl_ff;
      if (cmd.lvl_zero) begin
         lvl_in = '0;
      end else if (cmd.lvl_top) begin
         lvl_in = LVL_TOP;
      end else if (cmd.lvl_inc) begin
         lvl_in = lvl_ff + 1'b1;
      end else if (cmd.lvl_dec) begin
         lvl_in = lvl_ff - 1'b1;
      end
      node_in = node_ff;
      if (cmd.node_zero) begin
         node_in = '0;
      end else if (cmd.node_inc) begin
         node_in = node_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      db_ff   <= db_in;
      h_ff    <= h_in;
      res_ff  <= res_in;
      lvl_ff  <= lvl_in;
      node_ff <= node_in;
      if (cmd.push) begin
         out_data_ff <= res_ff;
      end
   end

   always_comb begin
      count_in     = csr_wen ? csr_wdata : count_ff;
      out_valid_in = cmd.push ? 1'b1 : (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= DEPTH_W'(MAX_NODES);
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Clamp the build range to the table size.
   always_comb begin
      build_cnt    = (count_ff > DEPTH_W'(MAX_NODES)) ? DEPTH_W'(MAX_NODES) : count_ff;
      build_cnt_m1 = build_cnt - 1'b1;
   end

   assign stat.build_empty    = (count_ff == '0) || (LEVELS < 2);
   assign stat.node_last      = (node_ff == build_cnt_m1[NODE_W-1:0]);
   assign stat.lvl_build_last = (lvl_ff == LVL_LAST);
   assign stat.lvl_is_zero    = (lvl_ff == '0);
   assign stat.pair_equal     = (a_ff == b_ff);
   assign stat.out_free       = ~out_valid_ff | rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign ancestor   = out_data_ff;

endmodule
`default_nettype wire

@@ design/blca_ctrl.sv @@
// Controller: sequences load, build and query steps over the datapath.
`default_nettype none
module blca_ctrl
   import blca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_op,
   input  wire stat_type    stat,
   output cmd_type          cmd
);

   state_type state_ff, state_in;
   op_type    op;
   logic      accept;

   assign op         = op_type'(req_op);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_BUILD: state_in = stat.build_empty ? ST_IDLE : ST_B_RD1;
                  OP_QUERY: state_in = ST_Q_SWAP;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_B_RD1:  state_in = ST_B_RD2;
         ST_B_RD2:  state_in = ST_B_WR;
         ST_B_WR: begin
            if (stat.node_last && stat.lvl_build_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_B_RD1;
            end
         end
         ST_Q_SWAP: state_in = ST_Q_L1;
         ST_Q_L1:   state_in = ST_Q_L2;
         ST_Q_L2:   state_in = ST_Q_L3;
         ST_Q_L3:   state_in = stat.lvl_is_zero ? ST_Q_EQ : ST_Q_L1;
         ST_Q_EQ:   state_in = stat.pair_equal ? ST_Q_FIN : ST_Q_M1;
         ST_Q_M1:   state_in = ST_Q_M2;
         ST_Q_M2:   state_in = stat.lvl_is_zero ? ST_Q_F1 : ST_Q_M1;
         ST_Q_F1:   state_in = ST_Q_F2;
         ST_Q_F2:   state_in = ST_Q_FIN;
         ST_Q_FIN:  state_in = stat.out_free ? ST_IDLE : ST_Q_FIN;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_LOAD:  cmd.load_wr = 1'b1;
                  OP_BUILD: begin
                     cmd.lvl_zero  = 1'b1;
                     cmd.node_zero = 1'b1;
                  end
                  OP_QUERY: cmd.q_start = 1'b1;
                  default:  cmd = '0;
               endcase
            end
         end
         ST_B_RD1: cmd.build_rd1 = 1'b1;
         ST_B_RD2: cmd.build_rd2 = 1'b1;
         ST_B_WR: begin
            cmd.build_wr = 1'b1;
            // wrap the node sweep, then advance to the next level
            if (stat.node_last) begin
               cmd.node_zero = 1'b1;
               cmd.lvl_inc   = ~stat.lvl_build_last;
            end else begin
               cmd.node_inc = 1'b1;
            end
         end
         ST_Q_SWAP: begin
            cmd.q_swap  = 1'b1;
            cmd.lvl_top = 1'b1;
         end
         ST_Q_L1: cmd.lift_rd       = 1'b1;
         ST_Q_L2: cmd.lift_depth_rd = 1'b1;
         ST_Q_L3: begin
            cmd.lift_upd = 1'b1;
            cmd.lvl_dec  = ~stat.lvl_is_zero;
         end
         ST_Q_EQ: begin
            cmd.res_from_a = stat.pair_equal;
            cmd.lvl_top    = ~stat.pair_equal;
         end
         ST_Q_M1: cmd.meet_rd = 1'b1;
         ST_Q_M2: begin
            cmd.meet_upd = 1'b1;
            cmd.lvl_dec  = ~stat.lvl_is_zero;
         end
         ST_Q_F1:  cmd.fin_rd      = 1'b1;
         ST_Q_F2:  cmd.res_from_rd = 1'b1;
         ST_Q_FIN: cmd.push        = stat.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ design/binary_lifting_lca_top.sv @@
// Top level of the binary lifting lowest common ancestor engine.
//
//   port group | dir | payload
//   req_       | in  | tuser: op; tdata: node_id, parent_id, node_depth, first_node, second_node
//   rsp_       | out | tdata: ancestor
//   csr_       | in  | wdata: node_count, written whenever csr_wen is high
//
// One word is in work at a time; req_tready is high only while the controller idles.
// Build: each node and level takes two dependent jump table reads on one read port
// before its write, over count nodes and LEVELS - 1 levels.
// Query: a lift over every level, then a meet over every level unless the lifted node meets the other;
// each lift level costs a table read and a depth read, each meet level one paired read.
// A result waits in the output register; a stalled rsp_ side holds only the next query.
// Synchronous reset clears the controller and the result valid and sets node_count to MAX_NODES;
// the stores are not cleared.
`default_nettype none
`include "binary_lifting_lca_top_defines.svh"
module binary_lifting_lca_top
   import blca_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [9:0] node_id, [19:10] parent_id, [30:20] node_depth, [40:31] first_node,
   // [50:41] second_node, [55:51] zero
   input  wire logic [55:0]  req_tdata,
   // [1:0] op
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [9:0] ancestor, [15:10] zero
   output logic [15:0]       rsp_tdata,
   input  wire logic         csr_wen,
   input  wire logic [10:0]  csr_wdata
);

   cmd_type           cmd;
   stat_type          stat;
   logic [NODE_W-1:0] ancestor;

   blca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   blca_dpath #(
      .LEVELS (LEVELS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .node_id     (req_tdata[9:0]),
      .parent_id   (req_tdata[19:10]),
      .node_depth  (req_tdata[30:20]),
      .first_node  (req_tdata[40:31]),
      .second_node (req_tdata[50:41]),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .ancestor    (ancestor)
   );

   assign rsp_tdata = {6'd0, ancestor};

   `BLCA_ASSERT_NEXT(a_query_busy, req_tvalid && req_tready && (req_tuser == OP_QUERY), !req_tready, "query accepted but ready stayed high")
   `BLCA_ASSERT_NOW(a_push_free, cmd.push, !rsp_tvalid || rsp_tready, "result pushed over a pending word")
   `BLCA_ASSERT_NEXT(a_build_order, cmd.build_rd2, cmd.build_wr, "build read not followed by its write")

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for the binary lifting ancestor engine: loads, builds, queries.
`timescale 1ns / 1ps
module tb_top;
   import blca_pkg::*;

   localparam int LEVELS = LEVELS_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int WORD_TARGET = 1400;

   // Mirror of the engine: jump table, depths and node_count; holds pending answers.
   class lca_tracker;
      bit [NODE_W-1:0] jump_tbl [MAX_NODES][LEVELS];
      bit [DEPTH_W-1:0] depth_mem [MAX_NODES];
      int unsigned node_limit;
      bit [NODE_W-1:0] due_ancestors [$];
      int errors;

      function new();
         node_limit = MAX_NODES;
         errors = 0;
      endfunction

      function void set_count(bit [10:0] value);
         node_limit = value;
      endfunction

      function int unsigned built_nodes();
         return (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
      endfunction

      function bit [NODE_W-1:0] lowest_common(bit [NODE_W-1:0] a, bit [NODE_W-1:0] b);
         bit [NODE_W-1:0] t, na, nb;
         if (depth_mem[a] < depth_mem[b]) begin
            t = a;
            a = b;
            b = t;
         end
         // lift the deeper node to the depth of the other
         for (int lv = LEVELS - 1; lv >= 0; lv--)
            if (depth_mem[jump_tbl[a][lv]] >= depth_mem[b])
               a = jump_tbl[a][lv];
         if (a == b)
            return a;
         for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            na = jump_tbl[a][lv];
            nb = jump_tbl[b][lv];
            if (na != nb) begin
               a = na;
               b = nb;
            end
         end
         return jump_tbl[a][0];
      endfunction

      function void take_word(logic [1:0] op, logic [55:0] data);
         int unsigned lim;
         lim = built_nodes();
         case (op)
            OP_LOAD: begin
               jump_tbl[data[9:0]][0] = data[19:10];
               depth_mem[data[9:0]] = data[30:20];
            end
            OP_BUILD: begin
               for (int lv = 0; lv + 1 < LEVELS; lv++)
                  for (int i = 0; i < lim; i++)
                     jump_tbl[i][lv + 1] = jump_tbl[jump_tbl[i][lv]][lv];
            end
            OP_QUERY: due_ancestors.push_back(lowest_common(data[40:31], data[50:41]));
            default: ;
         endcase
      endfunction

      function void match_ancestor(logic [NODE_W-1:0] got);
         bit [NODE_W-1:0] want;
         if (due_ancestors.size() == 0) begin
            $error("ancestor: expected none, got %0d", got);
            errors++;
            return;
         end
         want = due_ancestors.pop_front();
         if (got !== want) begin
            $error("ancestor: expected %0d, got %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [55:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [15:0] rsp_tdata;
   logic csr_wen;
   logic [10:0] csr_wdata;

   lca_tracker book = new();
   int words_sent = 0;
   int tail_cycles = 16;
   int cycle_count = 0;
   int slot_id [MAX_NODES];
   int slot_depth [MAX_NODES];
   wire calm = (words_sent >= 200) && (words_sent < 600);

   binary_lifting_lca_top #(.LEVELS(LEVELS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 8);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         book.match_ancestor(rsp_tdata[NODE_W-1:0]);

   function automatic logic [NODE_W-1:0] rnd_node();
      return NODE_W'($urandom_range(0, MAX_NODES - 1));
   endfunction

   function automatic logic [55:0] pack_word(input logic [9:0] id, par, input logic [10:0] dep,
                                             input logic [9:0] a, b);
      return {5'b0, b, a, dep, par, id};
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [55:0] data);
      while (!calm && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.take_word(op, data);
      if (op != OP_UNUSED)
         words_sent++;
      case (op)
         OP_BUILD: tail_cycles = 3 * book.built_nodes() * LEVELS + 64;
         OP_QUERY: tail_cycles = 6 * LEVELS + 32;
         default:  tail_cycles = 16;
      endcase
      @(negedge clock);
   endtask

   task automatic load_node(input logic [9:0] id, par, input logic [10:0] dep);
      send_word(OP_LOAD, pack_word(id, par, dep, rnd_node(), rnd_node()));
   endtask

   task automatic ask(input logic [9:0] a, b);
      send_word(OP_QUERY, pack_word(rnd_node(), rnd_node(), DEPTH_W'($urandom_range(0, 2047)),
                                    a, b));
   endtask

   task automatic send_build();
      send_word(OP_BUILD, pack_word(rnd_node(), rnd_node(), DEPTH_W'($urandom_range(0, 2047)),
                                    rnd_node(), rnd_node()));
   endtask

   task automatic send_unused();
      send_word(OP_UNUSED, pack_word(rnd_node(), rnd_node(), DEPTH_W'($urandom_range(0, 2047)),
                                     rnd_node(), rnd_node()));
   endtask

   // Drain all answers, then give a trailing build or query time to finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.due_ancestors.size() != 0) @(posedge clock);
      repeat (tail_cycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_count(input logic [10:0] value);
      settle();
      csr_wen <= 1'b1;
      csr_wdata <= value;
      book.set_count(value);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic stray_word();
      case ($urandom_range(0, 2))
         0: send_unused();
         1: load_node(rnd_node(), rnd_node(), DEPTH_W'($urandom_range(1, 1024)));
         default: ask(rnd_node(), rnd_node());
      endcase
   endtask

   // Count write, one random tree on a shuffled set of low node ids with stray words, then build and queries.
   task automatic grow_tree();
      int n, cnt, pick, nq, j, tmp, p, k;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 200) : $urandom_range(2, 48);
      pick = $urandom_range(0, 11);
      case (pick)
         0: cnt = 2047;
         1: cnt = 1024;
         2: cnt = $urandom_range(n, 1023);
         3: cnt = $urandom_range(0, n - 1);
         default: cnt = n;
      endcase
      write_count(DEPTH_W'(cnt));
      for (int i = 0; i < n; i++)
         slot_id[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slot_id[i];
         slot_id[i] = slot_id[j];
         slot_id[j] = tmp;
      end
      slot_depth[0] = 1;
      load_node(NODE_W'(slot_id[0]), NODE_W'(slot_id[0]), 11'd1);
      for (int i = 1; i < n; i++) begin
         // favor long chains so the lift runs through many levels
         p = ($urandom_range(0, 2) == 0) ? i - 1 : $urandom_range(0, i - 1);
         slot_depth[i] = slot_depth[p] + 1;
         if ($urandom_range(0, 15) == 0)
            stray_word();
         load_node(NODE_W'(slot_id[i]), NODE_W'(slot_id[p]), DEPTH_W'(slot_depth[i]));
      end
      send_build();
      nq = $urandom_range(4, 16);
      for (int q = 0; q < nq; q++) begin
         pick = $urandom_range(0, 7);
         k = slot_id[$urandom_range(0, n - 1)];
         if (pick == 0)
            ask(rnd_node(), rnd_node());
         else if (pick == 1)
            ask(NODE_W'(k), NODE_W'(k));
         else
            ask(NODE_W'(k), NODE_W'(slot_id[$urandom_range(0, n - 1)]));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOAD;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full chain rooted at node 1023 so every table entry is written once.
      write_count(11'd2047);
      for (int k = MAX_NODES - 1; k >= 0; k--)
         load_node(NODE_W'(k), NODE_W'((k == MAX_NODES - 1) ? k : k + 1),
                   DEPTH_W'(MAX_NODES - k));
      send_build();
      ask(0, 1023);
      ask(1023, 0);
      ask(0, 0);
      ask(1023, 1023);
      ask(511, 512);
      ask(0, 1);
      ask(300, 700);
      ask(1, 1022);
      send_unused();
      ask(0, 512);

      // empty build keeps the old table; single-node build touches only node 0
      write_count(11'd0);
      send_build();
      ask(5, 900);
      ask(1023, 17);
      write_count(11'd1);
      send_build();
      ask(0, 1);
      ask(2, 1000);

      while (words_sent < WORD_TARGET)
         grow_tree();

      settle();
      if (book.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/blca_pkg.sv
design/blca_dpath.sv
design/blca_ctrl.sv
design/binary_lifting_lca_top.sv
verif/tb_top.sv
